// ===== hdl/edvs_pkg.sv =====
`timescale 1ns / 1ps

package edvs_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned AHEAD_W = 12;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned PROD_W  = PRICE_W + AMT_W;
  // Day count before the month walk: largest day plus largest offset.
  localparam int unsigned DSUM_W  = 13;
  localparam int unsigned CFG_W   = 14;

  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_CYCLE      = 14'd400;
  localparam logic [YEAR_W-1:0]  CENTURY_1       = 14'd100;
  localparam logic [YEAR_W-1:0]  CENTURY_2       = 14'd200;
  localparam logic [YEAR_W-1:0]  CENTURY_3       = 14'd300;
  localparam logic [YEAR_W-1:0]  LAST_CYCLE_POS  = 14'd399;
  localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'h3FFF;
  // 400 << 5 is the largest power-of-two multiple of a leap cycle below 2^14.
  localparam logic [2:0]         CYCLE_SHIFT_MAX = 3'd5;

  typedef enum logic [1:0] {
    CFG_DAY   = 2'd0,
    CFG_MONTH = 2'd1,
    CFG_YEAR  = 2'd2,
    CFG_AHEAD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DAY_W-1:0]   item_day;
    logic [MONTH_W-1:0] item_month;
    logic [YEAR_W-1:0]  item_year;
    logic [PRICE_W-1:0] price_cents;
    logic [AMT_W-1:0]   amount;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_cents;
    logic               overflowed;
  } total_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic [AHEAD_W-1:0] days_ahead;
  } cfg_t;

  typedef struct packed {
    logic mul_en;
    logic match;
    logic acc_en;
    logic clr;
  } mac_ctrl_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/edvs_stream_if.sv =====
`timescale 1ns / 1ps

interface edvs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/expiry_date_value_sum.sv =====
// Expiry-date value sum. Items stream in on item_in; on the first item of a
// batch the block adds days_ahead to the configured reference date, walking
// month by month with Gregorian leap years, to form the target date. Every
// item whose expiry date equals the target adds price_cents * amount to a
// running total; the item flagged last sends the total (saturated at
// 2^48 - 1, with overflowed set) on total_out and starts a new batch.
// Structure: one shared 14-bit subtractor does the date work, one 20x16
// multiplier and one 48-bit adder do the sum. A regular item holds the input
// through accept, multiply and accumulate. The first item of a batch first
// runs the leap-cycle reduction, then one step per month stepped, then a
// closing step; at most about 140 months are stepped. The result sits in an
// output register, so the next batch starts while it waits; only a second
// last item stalls until the first total is taken.
// Configuration writes take effect at the next batch start.
`timescale 1ns / 1ps

module expiry_date_value_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [edvs_pkg::CFG_W-1:0]    cfg_wdata_i,
  edvs_stream_if.sink                   item_in,
  edvs_stream_if.source                 total_out
);
  import edvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DATE = 4'b0010,
    S_MUL  = 4'b0100,
    S_ACC  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  cfg_t       cfg_q;
  item_t      item_q;
  logic       tgt_ready_q, tgt_ready_d;
  total_t     out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       accept;
  logic       walk_start, walk_done;
  date_t      target;
  mac_ctrl_t  mac_ctrl;
  total_t     total_next;
  logic       slot_free;
  logic       match;

  // Configuration: plain register writes, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cur_day: DAY_W'(1), cur_month: MONTH_W'(1),
                 cur_year: YEAR_W'(2000), days_ahead: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DAY:   cfg_q.cur_day    <= cfg_wdata_i[DAY_W-1:0];
        CFG_MONTH: cfg_q.cur_month  <= cfg_wdata_i[MONTH_W-1:0];
        CFG_YEAR:  cfg_q.cur_year   <= cfg_wdata_i[YEAR_W-1:0];
        CFG_AHEAD: cfg_q.days_ahead <= cfg_wdata_i[AHEAD_W-1:0];
        default:   cfg_q            <= cfg_q;
      endcase
    end
  end

  // Take one item at a time; the sequencer owns the shared units meanwhile.
  assign item_in.ready = (state_q == S_IDLE);
  assign accept        = item_in.valid && item_in.ready;
  assign walk_start    = accept && !tgt_ready_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in.payload;
    end
  end

  edvs_datewalk u_datewalk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start),
    .cfg_i    (cfg_q),
    .done_o   (walk_done),
    .target_o (target)
  );

  // Field-for-field compare; out-of-range item dates simply miss.
  assign match = (item_q.item_day == target.day) &&
                 (item_q.item_month == target.month) &&
                 (item_q.item_year == target.year);

  // The output slot is free when empty or when its transfer completes now.
  assign slot_free = !out_valid_q || total_out.ready;

  always_comb begin
    mac_ctrl.mul_en = (state_q == S_MUL);
    mac_ctrl.match  = match;
    mac_ctrl.acc_en = (state_q == S_ACC) && (!item_q.last || slot_free);
    mac_ctrl.clr    = mac_ctrl.acc_en && item_q.last;
  end

  edvs_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .price_i  (item_q.price_cents),
    .amount_i (item_q.amount),
    .total_o  (total_next)
  );

  always_comb begin
    state_d     = state_q;
    tgt_ready_d = tgt_ready_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !total_out.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = tgt_ready_q ? S_MUL : S_DATE;
        end
      end
      S_DATE: begin
        // Hold until the walk latches the target.
        if (walk_done) begin
          tgt_ready_d = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (mac_ctrl.acc_en) begin
          if (item_q.last) begin
            // Emit the total, then recompute the target on the next batch.
            out_d       = total_next;
            out_valid_d = 1'b1;
            tgt_ready_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_ready_q <= tgt_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign total_out.valid   = out_valid_q;
  assign total_out.payload = out_q;

endmodule

// ===== hdl/edvs_datewalk.sv =====
`timescale 1ns / 1ps

module edvs_datewalk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  edvs_pkg::cfg_t cfg_i,
  output logic           done_o,
  output edvs_pkg::date_t target_o
);
  import edvs_pkg::*;

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_MOD  = 3'b010,
    W_WALK = 3'b100
  } walk_state_e;

  walk_state_e          state_q, state_d;
  logic [2:0]           k_q, k_d;
  logic [DSUM_W-1:0]    d_q, d_d;
  logic [MONTH_W-1:0]   m_q, m_d;
  logic [YEAR_W-1:0]    y_q, y_d;
  logic [YEAR_W-1:0]    r_q, r_d;
  date_t                tgt_q, tgt_d;

  logic [YEAR_W-1:0]    sub_a, sub_b;
  logic [YEAR_W:0]      sub_diff;
  logic                 borrow, leap, step_more;
  logic [DAY_W-1:0]     mdays;
  logic [MONTH_W-1:0]   m_start;

  // Position of the year in its 400-year cycle picks out century years.
  assign leap = (y_q[1:0] == 2'd0) &&
                !(r_q == CENTURY_1 || r_q == CENTURY_2 || r_q == CENTURY_3);
  assign mdays = month_days(m_q, leap);

  // Shared subtractor: leap-cycle reduction, then the month walk.
  always_comb begin
    if (state_q == W_WALK) begin
      sub_a = YEAR_W'(d_q);
      sub_b = YEAR_W'(mdays);
    end else begin
      sub_a = r_q;
      sub_b = YEAR_CYCLE << k_q;
    end
  end

  assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow    = sub_diff[YEAR_W];
  assign step_more = !borrow && (sub_diff[YEAR_W-1:0] != '0);

  always_comb begin
    if (cfg_i.cur_month == '0) begin
      m_start = MONTH_W'(1);
    end else if (cfg_i.cur_month > MONTHS_PER_YEAR) begin
      m_start = MONTHS_PER_YEAR;
    end else begin
      m_start = cfg_i.cur_month;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    r_d     = r_q;
    tgt_d   = tgt_q;
    done_o  = 1'b0;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          d_d     = DSUM_W'(cfg_i.cur_day) + DSUM_W'(cfg_i.days_ahead);
          m_d     = m_start;
          y_d     = cfg_i.cur_year;
          r_d     = cfg_i.cur_year;
          k_d     = CYCLE_SHIFT_MAX;
          state_d = W_MOD;
        end
      end
      W_MOD: begin
        if (!borrow) begin
          r_d = sub_diff[YEAR_W-1:0];
        end
        k_d = k_q - 3'd1;
        if (k_q == '0) begin
          state_d = W_WALK;
        end
      end
      W_WALK: begin
        if (step_more) begin
          d_d = sub_diff[DSUM_W-1:0];
          if (m_q == MONTHS_PER_YEAR) begin
            m_d = MONTH_W'(1);
            y_d = y_q + YEAR_W'(1);
            if (y_q == YEAR_MAX || r_q == LAST_CYCLE_POS) begin
              r_d = '0;
            end else begin
              r_d = r_q + YEAR_W'(1);
            end
          end else begin
            m_d = m_q + MONTH_W'(1);
          end
        end else begin
          tgt_d   = '{day: d_q[DAY_W-1:0], month: m_q, year: y_q};
          done_o  = 1'b1;
          state_d = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      k_q     <= '0;
      tgt_q   <= '{day: DAY_W'(1), month: MONTH_W'(1), year: YEAR_W'(1)};
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      tgt_q   <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    m_q <= m_d;
    y_q <= y_d;
    r_q <= r_d;
  end

  assign target_o = tgt_q;

endmodule

// ===== hdl/edvs_mac.sv =====
`timescale 1ns / 1ps

module edvs_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  edvs_pkg::mac_ctrl_t               ctrl_i,
  input  logic [edvs_pkg::PRICE_W-1:0]      price_i,
  input  logic [edvs_pkg::AMT_W-1:0]        amount_i,
  output edvs_pkg::total_t                  total_o
);
  import edvs_pkg::*;

  logic [PROD_W-1:0]  prod_q;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               sat_q, sat_d;
  logic [TOTAL_W:0]   sum;
  logic               over;
  logic [TOTAL_W-1:0] total_next;
  logic               sat_next;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ctrl_i.match ? PROD_W'(price_i) * PROD_W'(amount_i) : '0;
    end
  end

  assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(prod_q);
  assign over       = sum[TOTAL_W];
  assign total_next = over ? '1 : sum[TOTAL_W-1:0];
  assign sat_next   = sat_q | over;

  // Clear wins: the emitted total already includes this item.
  always_comb begin
    total_d = total_q;
    sat_d   = sat_q;
    if (ctrl_i.clr) begin
      total_d = '0;
      sat_d   = 1'b0;
    end else if (ctrl_i.acc_en) begin
      total_d = total_next;
      sat_d   = sat_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      sat_q   <= sat_d;
    end
  end

  assign total_o = '{total_cents: total_next, overflowed: sat_next};

endmodule

// ===== hdl/edvs_checker.sv =====
`timescale 1ns / 1ps

module edvs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           item_valid_i,
  input logic                           item_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [edvs_pkg::TOTAL_W-1:0]   out_total_i,
  input logic                           out_overflowed_i
);
  import edvs_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_total_i) &&
    $stable(out_overflowed_i))
    else $error("stalled result changed or dropped");

  // A saturated total must read as the maximum.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflowed_i |-> out_total_i == {TOTAL_W{1'b1}})
    else $error("overflow flagged on a non-saturated total");

  // One item at a time: drop ready right after a transfer.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i |=> !item_ready_i)
    else $error("input ready directly after a transfer");

  // A new result appears only out of the accumulate step, never from idle.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(item_ready_i))
    else $error("result appeared without an item in progress");

endmodule

bind expiry_date_value_sum edvs_checker u_edvs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .item_valid_i     (item_in.valid),
  .item_ready_i     (item_in.ready),
  .out_valid_i      (total_out.valid),
  .out_ready_i      (total_out.ready),
  .out_total_i      (total_out.payload.total_cents),
  .out_overflowed_i (total_out.payload.overflowed)
);
